// ===== src/mma_pkg.sv =====
// Package for the multimode moving average: widths, modes, register indexes
// and the reciprocal function. No dependencies.
package mma_pkg;
    localparam int WINDOW_MAX_DEF      = 128;
    localparam int SAMPLE_BITS_DEF     = 16;
    localparam int ALPHA_FRAC_BITS_DEF = 16;
    localparam int STATE_FRAC          = 16;
    localparam int RECIP_BITS          = 24;
    localparam int CFG_IDX_BITS        = 2;
    localparam int CFG_DATA_BITS       = 32;

    localparam logic [1:0] MODE_SMA  = 2'd0;
    localparam logic [1:0] MODE_EMA  = 2'd1;
    localparam logic [1:0] MODE_DEMA = 2'd2;
    localparam logic [1:0] MODE_TEMA = 2'd3;

    localparam logic [CFG_IDX_BITS-1:0] REG_MODE   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_ALPHA  = 2'd2;

    function automatic logic [RECIP_BITS:0] recip(input logic [10:0] k);
        logic [RECIP_BITS:0] r;
        r = '0;
        for (int i = 1; i <= 255; i++) begin
            if (int'(k) == i) begin
                r = (RECIP_BITS+1)'(((64'd1 << RECIP_BITS) + 64'(i / 2)) / 64'(i));
            end
        end
        return r;
    endfunction
endpackage

// ===== src/multimode_moving_average.sv =====
// Multimode moving average top level. Depends on mma_pkg and mma_ring.
// From acceptance to the output register an item passes through ring and sum
// update with the first exponential stage, the second stage, the third stage,
// the output multiplies and the rounding into the output register.
// A new item is taken only once the result has left the output register, so
// items do not overlap; an output stall delays the next item.
// Reset clears control state, the sums and stages; config regs take defaults.
module multimode_moving_average #(
    parameter int WINDOW_MAX      = mma_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS     = mma_pkg::SAMPLE_BITS_DEF,
    parameter int ALPHA_FRAC_BITS = mma_pkg::ALPHA_FRAC_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [mma_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [mma_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [SAMPLE_BITS-1:0]        sample_re,
    input  logic signed [SAMPLE_BITS-1:0]        sample_im,
    input  logic                                 first_of_series,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [SAMPLE_BITS-1:0]        avg_re,
    output logic signed [SAMPLE_BITS-1:0]        avg_im,
    output logic                                 saturated
);
    import mma_pkg::*;

    localparam int AW = $clog2(WINDOW_MAX);
    localparam int CW = $clog2(WINDOW_MAX + 1);
    localparam int SUMW = SAMPLE_BITS + AW + 1;
    localparam int STW = SAMPLE_BITS + STATE_FRAC + 2;
    localparam int AB = ALPHA_FRAC_BITS + 1;
    localparam int VW = STW + 3;
    localparam int PW = SUMW + RECIP_BITS + 1;
    localparam logic [AB-1:0] ALPHA_ONE = AB'(1) << ALPHA_FRAC_BITS;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001, S_UPD = 6'b000010, S_ST1 = 6'b000100,
        S_ST2 = 6'b001000, S_MUL = 6'b010000, S_OUT = 6'b100000
    } state_t;

    state_t state_reg;
    logic [1:0] mode_reg;
    logic [7:0] wsize_reg;
    logic [AB-1:0] alpha_reg;
    logic [AW-1:0] head_reg;
    logic [CW-1:0] fill_reg;
    logic signed [SUMW-1:0] sum_re_reg, sum_im_reg;
    logic signed [STW-1:0] st_re_reg [3];
    logic signed [STW-1:0] st_im_reg [3];
    logic signed [SAMPLE_BITS-1:0] x_re_reg, x_im_reg;
    logic first_reg;
    logic [CW-1:0] k_reg;
    logic signed [PW-1:0] p_re_reg, p_im_reg;
    logic signed [VW-1:0] v_re_reg, v_im_reg;
    logic signed [SAMPLE_BITS-1:0] o_re_reg, o_im_reg;
    logic o_sat_reg, o_valid_reg;

    logic [CW-1:0] n_eff, fill_c;
    logic [AW-1:0] head_c, slot;
    logic [AB-1:0] a_eff;
    logic [2*SAMPLE_BITS-1:0] rdata;
    logic accept;

    assign accept = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE) || o_valid_reg;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        if (wsize_reg == 8'd0) n_eff = CW'(1);
        else if (int'(wsize_reg) > WINDOW_MAX) n_eff = CW'(WINDOW_MAX);
        else n_eff = CW'(wsize_reg);
        fill_c = (first_reg || fill_reg > n_eff) ? ((first_reg) ? '0 : n_eff) : fill_reg;
        head_c = (first_reg || CW'(head_reg) >= n_eff) ? '0 : head_reg;
        a_eff = (alpha_reg > ALPHA_ONE) ? ALPHA_ONE : alpha_reg;
    end

    // The read address is formed in idle from the pre-update state.
    logic [AW-1:0] head_i;
    always_comb
    begin
        head_i = (CW'(head_reg) >= n_eff) ? '0 : head_reg;
        slot = (fill_c < n_eff) ? fill_c[AW-1:0] : head_c;
    end

    mma_ring #(.DEPTH(WINDOW_MAX), .WIDTH(2*SAMPLE_BITS)) u_ring (
        .clk(clk), .we(state_reg == S_UPD), .waddr(slot),
        .wdata({x_re_reg, x_im_reg}), .raddr(head_i), .rdata(rdata)
    );

    function automatic logic signed [STW-1:0] ema(
        input logic signed [STW-1:0] e, input logic signed [STW-1:0] u,
        input logic [AB-1:0] a);
        logic signed [STW+AB+1:0] pr;
        pr = $signed({1'b0, a}) * (u - e) + $signed((STW+AB+2)'(ALPHA_ONE >> 1));
        return e + STW'(pr >>> ALPHA_FRAC_BITS);
    endfunction

    // One exponential stage is updated per cycle, stage 0 in S_UPD.
    logic signed [STW-1:0] u_re, u_im, e_re, e_im, src_re, src_im, n_re, n_im;
    always_comb
    begin
        u_re = STW'(x_re_reg) <<< STATE_FRAC;
        u_im = STW'(x_im_reg) <<< STATE_FRAC;
        unique case (state_reg)
            S_ST1:
            begin
                e_re = st_re_reg[1];
                e_im = st_im_reg[1];
                src_re = st_re_reg[0];
                src_im = st_im_reg[0];
            end
            S_ST2:
            begin
                e_re = st_re_reg[2];
                e_im = st_im_reg[2];
                src_re = st_re_reg[1];
                src_im = st_im_reg[1];
            end
            default:
            begin
                e_re = st_re_reg[0];
                e_im = st_im_reg[0];
                src_re = u_re;
                src_im = u_im;
            end
        endcase
        if (first_reg)
        begin
            e_re = u_re;
            e_im = u_im;
        end
        n_re = ema(e_re, src_re, a_eff);
        n_im = ema(e_im, src_im, a_eff);
    end

    function automatic logic signed [SAMPLE_BITS:0] clip(
        input logic signed [PW+1:0] v);
        logic signed [PW+1:0] mx, mn;
        mx = (PW+2)'((1 << (SAMPLE_BITS-1)) - 1);
        mn = -(PW+2)'(1 << (SAMPLE_BITS-1));
        if (v > mx) return {1'b1, SAMPLE_BITS'(mx)};
        if (v < mn) return {1'b1, SAMPLE_BITS'(mn)};
        return {1'b0, SAMPLE_BITS'(v)};
    endfunction

    logic signed [PW+1:0] r_re, r_im;
    logic signed [SAMPLE_BITS:0] c_re, c_im;
    always_comb
    begin
        if (mode_reg == MODE_SMA)
        begin
            r_re = (PW+2)'(p_re_reg + (PW)'(1 << (RECIP_BITS-1))) >>> RECIP_BITS;
            r_im = (PW+2)'(p_im_reg + (PW)'(1 << (RECIP_BITS-1))) >>> RECIP_BITS;
        end
        else
        begin
            r_re = (PW+2)'((v_re_reg + VW'(1 << (STATE_FRAC-1))) >>> STATE_FRAC);
            r_im = (PW+2)'((v_im_reg + VW'(1 << (STATE_FRAC-1))) >>> STATE_FRAC);
        end
        c_re = clip(r_re);
        c_im = clip(r_im);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            mode_reg <= MODE_SMA;
            wsize_reg <= 8'd1;
            alpha_reg <= ALPHA_ONE;
            head_reg <= '0;
            fill_reg <= '0;
            sum_re_reg <= '0;
            sum_im_reg <= '0;
            o_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                st_re_reg[i] <= '0;
                st_im_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_MODE:   mode_reg <= cfg_data[1:0];
                    REG_WINDOW: wsize_reg <= cfg_data[7:0];
                    REG_ALPHA:  alpha_reg <= cfg_data[AB-1:0];
                    default: ;
                endcase
            end
            if (o_valid_reg && !out_stall) o_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept) state_reg <= S_UPD;
                end
                S_UPD:
                begin
                    if (fill_c < n_eff)
                    begin
                        fill_reg <= fill_c + CW'(1);
                        head_reg <= head_c;
                        sum_re_reg <= (first_reg ? '0 : sum_re_reg) + SUMW'(x_re_reg);
                        sum_im_reg <= (first_reg ? '0 : sum_im_reg) + SUMW'(x_im_reg);
                    end
                    else
                    begin
                        fill_reg <= fill_c;
                        head_reg <= (CW'(head_c) + CW'(1) >= n_eff) ? '0 : head_c + AW'(1);
                        sum_re_reg <= sum_re_reg + SUMW'(x_re_reg)
                            - SUMW'($signed(rdata[2*SAMPLE_BITS-1:SAMPLE_BITS]));
                        sum_im_reg <= sum_im_reg + SUMW'(x_im_reg)
                            - SUMW'($signed(rdata[SAMPLE_BITS-1:0]));
                    end
                    k_reg <= (fill_c < n_eff) ? fill_c + CW'(1) : n_eff;
                    st_re_reg[0] <= n_re;
                    st_im_reg[0] <= n_im;
                    state_reg <= S_ST1;
                end
                S_ST1:
                begin
                    st_re_reg[1] <= n_re;
                    st_im_reg[1] <= n_im;
                    state_reg <= S_ST2;
                end
                S_ST2:
                begin
                    st_re_reg[2] <= n_re;
                    st_im_reg[2] <= n_im;
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    p_re_reg <= PW'(sum_re_reg) * PW'($signed({1'b0, recip(11'(k_reg))}));
                    p_im_reg <= PW'(sum_im_reg) * PW'($signed({1'b0, recip(11'(k_reg))}));
                    priority case (mode_reg)
                        MODE_EMA:
                        begin
                            v_re_reg <= VW'(st_re_reg[0]);
                            v_im_reg <= VW'(st_im_reg[0]);
                        end
                        MODE_DEMA:
                        begin
                            v_re_reg <= 2 * VW'(st_re_reg[0]) - VW'(st_re_reg[1]);
                            v_im_reg <= 2 * VW'(st_im_reg[0]) - VW'(st_im_reg[1]);
                        end
                        default:
                        begin
                            v_re_reg <= 3 * VW'(st_re_reg[0]) - 3 * VW'(st_re_reg[1])
                                + VW'(st_re_reg[2]);
                            v_im_reg <= 3 * VW'(st_im_reg[0]) - 3 * VW'(st_im_reg[1])
                                + VW'(st_im_reg[2]);
                        end
                    endcase
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    o_valid_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_re_reg <= sample_re;
            x_im_reg <= sample_im;
            first_reg <= first_of_series;
        end
        if (state_reg == S_OUT)
        begin
            o_re_reg <= c_re[SAMPLE_BITS-1:0];
            o_im_reg <= c_im[SAMPLE_BITS-1:0];
            o_sat_reg <= c_re[SAMPLE_BITS] | c_im[SAMPLE_BITS];
        end
    end

    assign out_valid = o_valid_reg;
    assign avg_re = o_re_reg;
    assign avg_im = o_im_reg;
    assign saturated = o_sat_reg;

`ifndef NO_ASSERTIONS
    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(WINDOW_MAX)) else $error("fill count beyond window");
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> in_stall) else $error("item taken while busy");
    a_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT) |=> o_valid_reg) else $error("result lost");
`endif
endmodule

// ===== src/mma_ring.sv =====
// Window ring memory for the simple average: one write port, one registered
// read port. Depends on mma_pkg.
module mma_ring #(
    parameter int DEPTH = mma_pkg::WINDOW_MAX_DEF,
    parameter int WIDTH = 2 * mma_pkg::SAMPLE_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    import mma_pkg::*;
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== dv/multimode_moving_average_test.sv =====
// Self-checking testbench for multimode_moving_average: drives random and directed
// sample items, predicts every filtered item in all four modes and compares them.
// Depends on mma_pkg and the block's RTL.
module multimode_moving_average_test;
    import mma_pkg::*;

    typedef struct {
        logic signed [15:0] re;
        logic signed [15:0] im;
        logic               first;
    } sample_t;

    typedef struct {
        logic signed [15:0] re;
        logic signed [15:0] im;
        logic               sat;
    } filtered_t;

    localparam int CYCLE_LIMIT = 400000;
    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE = 2'd3;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;
    logic                     in_valid;
    logic                     in_stall;
    logic signed [15:0]       sample_re;
    logic signed [15:0]       sample_im;
    logic                     first_of_series;
    logic                     out_valid;
    logic                     out_stall;
    logic signed [15:0]       avg_re;
    logic signed [15:0]       avg_im;
    logic                     saturated;

    sample_t   pending_samples[$];
    filtered_t expected_outputs[$];

    logic [1:0]  cur_mode;
    logic [7:0]  cur_window;
    logic [16:0] cur_alpha;
    longint      ring_re[WINDOW_MAX_DEF];
    longint      ring_im[WINDOW_MAX_DEF];
    int          head;
    int          fill;
    longint      acc_re;
    longint      acc_im;
    longint      st_re[3];
    longint      st_im[3];

    int  queued_total;
    int  accepted_total;
    int  results_total;
    int  mismatches;
    int  cycles;
    logic took;
    logic quiet;

    multimode_moving_average DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .sample_re(sample_re), .sample_im(sample_im),
        .first_of_series(first_of_series),
        .out_valid(out_valid), .out_stall(out_stall),
        .avg_re(avg_re), .avg_im(avg_im), .saturated(saturated)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic longint clip16(input longint v, inout logic flag);
        if (v > 32767)
        begin
            flag = 1'b1;
            return 32767;
        end
        if (v < -32768)
        begin
            flag = 1'b1;
            return -32768;
        end
        return v;
    endfunction

    function void filter_sample(input sample_t s);
        longint    xr, xi, ur, ui, a, vr, vi, rc, rr, ri;
        int        n, k;
        logic      flag;
        filtered_t r;
        xr = s.re;
        xi = s.im;
        flag = 1'b0;
        if (s.first)
        begin
            head = 0;
            fill = 0;
            acc_re = 0;
            acc_im = 0;
            for (int i = 0; i < 3; i++)
            begin
                st_re[i] = xr * 65536;
                st_im[i] = xi * 65536;
            end
        end
        n = cur_window;
        if (n == 0)
            n = 1;
        if (n > WINDOW_MAX_DEF)
            n = WINDOW_MAX_DEF;
        if (fill > n)
            fill = n;
        if (head >= n)
            head = 0;
        if (fill < n)
        begin
            ring_re[fill] = xr;
            ring_im[fill] = xi;
            acc_re += xr;
            acc_im += xi;
            fill++;
            k = fill;
        end
        else
        begin
            acc_re += xr - ring_re[head];
            acc_im += xi - ring_im[head];
            ring_re[head] = xr;
            ring_im[head] = xi;
            head = (head + 1 >= n) ? 0 : head + 1;
            k = n;
        end
        a = (cur_alpha > 65536) ? 65536 : cur_alpha;
        ur = xr * 65536;
        ui = xi * 65536;
        for (int i = 0; i < 3; i++)
        begin
            st_re[i] = st_re[i] + ((a * (ur - st_re[i]) + 32768) >>> 16);
            st_im[i] = st_im[i] + ((a * (ui - st_im[i]) + 32768) >>> 16);
            ur = st_re[i];
            ui = st_im[i];
        end
        if (cur_mode == MODE_SMA)
        begin
            rc = (64'sd16777216 + k / 2) / k;
            rr = (acc_re * rc + 64'sd8388608) >>> 24;
            ri = (acc_im * rc + 64'sd8388608) >>> 24;
        end
        else
        begin
            if (cur_mode == MODE_EMA)
            begin
                vr = st_re[0];
                vi = st_im[0];
            end
            else if (cur_mode == MODE_DEMA)
            begin
                vr = 2 * st_re[0] - st_re[1];
                vi = 2 * st_im[0] - st_im[1];
            end
            else
            begin
                vr = 3 * st_re[0] - 3 * st_re[1] + st_re[2];
                vi = 3 * st_im[0] - 3 * st_im[1] + st_im[2];
            end
            rr = (vr + 32768) >>> 16;
            ri = (vi + 32768) >>> 16;
        end
        r.re = 16'(clip16(rr, flag));
        r.im = 16'(clip16(ri, flag));
        r.sat = flag;
        expected_outputs.push_back(r);
    endfunction

    task add_sample(input int re, input int im, input logic first);
        sample_t s;
        s.re = 16'(re);
        s.im = 16'(im);
        s.first = first;
        pending_samples.push_back(s);
        queued_total++;
    endtask

    task wait_idle();
        forever
        begin
            @(negedge clk);
            if (accepted_total == queued_total && results_total == accepted_total)
                break;
        end
        repeat (8) @(posedge clk);
    endtask

    task write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [31:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        forever
        begin
            @(posedge clk);
            if (cfg_ready)
                break;
        end
        if (idx == REG_MODE)
            cur_mode = value[1:0];
        else if (idx == REG_WINDOW)
            cur_window = value[7:0];
        else if (idx == REG_ALPHA)
            cur_alpha = value[16:0];
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function int random_value();
        case ($urandom_range(9))
            0: return -32768;
            1: return 32767;
            2: return $urandom_range(1) ? 32767 - $urandom_range(300) : -32768 + $urandom_range(300);
            default: return int'(16'($urandom));
        endcase
    endfunction

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
        if (in_valid && !in_stall)
        begin
            sample_t s;
            s.re = sample_re;
            s.im = sample_im;
            s.first = first_of_series;
            filter_sample(s);
            accepted_total++;
            took <= 1'b1;
        end
        if (out_valid && !out_stall)
        begin
            results_total++;
            if (expected_outputs.size() == 0)
            begin
                $error("unexpected item: avg_re %0d avg_im %0d", avg_re, avg_im);
                mismatches++;
            end
            else
            begin
                filtered_t e;
                e = expected_outputs.pop_front();
                if (avg_re !== e.re)
                begin
                    $error("avg_re: expected %0d, actual %0d", e.re, avg_re);
                    mismatches++;
                end
                if (avg_im !== e.im)
                begin
                    $error("avg_im: expected %0d, actual %0d", e.im, avg_im);
                    mismatches++;
                end
                if (saturated !== e.sat)
                begin
                    $error("saturated: expected %0d, actual %0d", e.sat, saturated);
                    mismatches++;
                end
            end
        end
    end

    always @(negedge clk)
    begin
        quiet = (accepted_total >= 700 && accepted_total < 1000);
        if (rst_n && (!in_valid || took))
        begin
            if (pending_samples.size() > 0 && (quiet || $urandom_range(99) >= 11))
            begin
                sample_t s;
                s = pending_samples.pop_front();
                in_valid <= 1'b1;
                sample_re <= s.re;
                sample_im <= s.im;
                first_of_series <= s.first;
            end
            else
                in_valid <= 1'b0;
        end
        took <= 1'b0;
        out_stall <= rst_n && !quiet && ($urandom_range(99) < 11);
    end

    initial
    begin
        int  count;
        int  len;
        int  w;
        logic [16:0] al;
        clk = 1'b1;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        sample_re = '0;
        sample_im = '0;
        first_of_series = 1'b0;
        out_stall = 1'b0;
        took = 1'b0;
        quiet = 1'b0;
        cur_mode = MODE_SMA;
        cur_window = 8'd1;
        cur_alpha = 17'd65536;
        head = 0;
        fill = 0;
        acc_re = 0;
        acc_im = 0;
        for (int i = 0; i < 3; i++)
        begin
            st_re[i] = 0;
            st_im[i] = 0;
        end
        queued_total = 0;
        accepted_total = 0;
        results_total = 0;
        mismatches = 0;
        cycles = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Items before any series has started, with the reset settings.
        add_sample(32767, -32768, 1'b0);
        add_sample(-1, 1, 1'b0);
        wait_idle();
        write_reg(REG_WINDOW, 32'd4);
        add_sample(-32768, -32768, 1'b1);
        add_sample(-32768, -32768, 1'b0);
        add_sample(32767, 32767, 1'b0);
        add_sample(32767, 0, 1'b0);
        add_sample(0, 32767, 1'b0);
        add_sample(-1, -1, 1'b0);
        wait_idle();
        write_reg(REG_WINDOW, 32'd0);
        write_reg(REG_MODE, 32'(MODE_TEMA));
        write_reg(REG_ALPHA, 32'd30000);
        add_sample(-32768, 32767, 1'b1);
        add_sample(32767, -32768, 1'b0);
        add_sample(32767, -32768, 1'b0);
        wait_idle();
        write_reg(REG_MODE, 32'(MODE_DEMA));
        write_reg(REG_ALPHA, 32'h1FFFF);
        write_reg(REG_SPARE, 32'hDEADBEEF);
        add_sample(12345, -12345, 1'b0);
        add_sample(-32768, 32767, 1'b0);
        wait_idle();
        write_reg(REG_MODE, 32'(MODE_EMA));
        write_reg(REG_ALPHA, 32'd0);
        write_reg(REG_WINDOW, 32'd255);
        add_sample(100, -100, 1'b1);
        add_sample(32767, -32768, 1'b0);
        wait_idle();
        write_reg(REG_MODE, 32'(MODE_SMA));
        add_sample(32767, 32767, 1'b0);
        add_sample(-32768, -32768, 1'b0);
        wait_idle();

        count = 0;
        while (count < 1550)
        begin
            write_reg(REG_MODE, 32'($urandom_range(3)));
            case ($urandom_range(15))
                0: w = 128;
                1: w = $urandom_range(255);
                2: w = $urandom_range(129, 255);
                default: w = $urandom_range(1, 16);
            endcase
            if ($urandom_range(3) != 0)
                write_reg(REG_WINDOW, 32'(w) | ($urandom & 32'hFFFFFF00));
            case ($urandom_range(11))
                0: al = 17'd0;
                1: al = 17'd65536;
                2: al = 17'($urandom_range(65537, 131071));
                3: al = 17'($urandom);
                default: al = 17'($urandom_range(1000, 65535));
            endcase
            if ($urandom_range(3) != 0)
                write_reg(REG_ALPHA, 32'(al) | ($urandom & 32'hFFFE0000));
            if ($urandom_range(15) == 0)
                write_reg(REG_SPARE, $urandom);
            len = (w > 32) ? $urandom_range(150, 250) : $urandom_range(15, 80);
            if (len > 1550 - count)
                len = 1550 - count;
            for (int i = 0; i < len; i++)
            begin
                add_sample(random_value(), random_value(),
                           (i == 0) ? ($urandom_range(9) != 0) : ($urandom_range(49) == 0));
                count++;
            end
            wait_idle();
        end

        wait_idle();
        repeat (16) @(posedge clk);
        if (mismatches == 0 && expected_outputs.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

// ===== files.f =====
src/mma_pkg.sv
src/mma_ring.sv
src/multimode_moving_average.sv
dv/multimode_moving_average_test.sv
